/* sv/cst_pkg.sv */
// Shared types and codes for the counting semaphore table.
package cst_pkg;

  // Request type codes.
  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_WAIT     = 2'd1,
    REQ_SIGNAL   = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_QFULL   = 3'd4,
    ST_SAT     = 3'd5
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_WAKE,
    S_RESULT
  } state_e;

  // Count limits of the 8-bit two's complement count.
  localparam logic signed [7:0] COUNT_MAX = 8'sd127;
  localparam logic signed [7:0] COUNT_MIN = -8'sd128;

  localparam int CountW = 8;
  localparam int InitW  = 7;

  // One result item.
  typedef struct packed {
    status_e                 status;
    logic                    blocked;
    logic                    wake_valid;
    logic [7:0]              wake_process;
    logic signed [CountW-1:0] count_after;
  } res_t;

endpackage

/* sv/counting_semaphore_table.sv */
// A request with no type goes from acceptance straight to the result state and then
// to out_valid_o. Other requests scan one stored key per cycle, stopping at a match
// or at the last used slot; a miss then goes to the result state, a hit reads the slot
// entry, and a signal that wakes a waiter also reads the waiter queue before the result.
// Throughput: one request at a time; the next is accepted the cycle after its
// result moves into the output register.
// Reset clears the sequencer, the fill count and the output valid and sets
// initial_count to 1; the memories are not cleared, the fill count guards them.
module counting_semaphore_table #(
  parameter int NUM_SEMS    = 16,
  parameter int MAX_WAITERS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cst_pkg::InitW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [15:0]               sem_key_i,
  input  logic [7:0]                process_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                status_o,
  output logic                      blocked_o,
  output logic                      wake_valid_o,
  output logic [7:0]                wake_process_o,
  output logic signed [7:0]         count_after_o
);
  import cst_pkg::*;

  logic [InitW-1:0] init_count_q;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_count_q <= InitW'(1);
    end else if (cfg_valid_i) begin
      init_count_q <= cfg_data_i;
    end
  end

  cst_ctrl #(.NUM_SEMS(NUM_SEMS), .MAX_WAITERS(MAX_WAITERS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .sem_key_i    (sem_key_i),
    .process_id_i (process_id_i),
    .init_count_i (init_count_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // Output register parts the sequencer from the downstream stall.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign blocked_o      = out_res_q.blocked;
  assign wake_valid_o   = out_res_q.wake_valid;
  assign wake_process_o = out_res_q.wake_process;
  assign count_after_o  = out_res_q.count_after;

endmodule

/* sv/cst_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module cst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cst_ctrl.sv */
// Request sequencer: key scan, read-modify-write of slot state and wait queues.
module cst_ctrl #(
  parameter int NUM_SEMS    = 16,
  parameter int MAX_WAITERS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [15:0]                sem_key_i,
  input  logic [7:0]                 process_id_i,
  input  logic [cst_pkg::InitW-1:0]  init_count_i,
  output logic                       res_valid_o,
  output cst_pkg::res_t              res_o,
  input  logic                       res_ready_i
);
  import cst_pkg::*;

  localparam int SW  = $clog2(NUM_SEMS);
  localparam int UW  = $clog2(NUM_SEMS + 1);
  localparam int QW  = $clog2(MAX_WAITERS);
  localparam int WD  = NUM_SEMS * MAX_WAITERS;
  localparam int WAW = $clog2(WD);
  localparam int SLW = CountW + 2 * QW;
  localparam logic signed [9:0] CountLim = 10'(-MAX_WAITERS);

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [15:0]       key_q, key_d;
  logic [7:0]        pid_q, pid_d;
  logic [SW-1:0]     idx_q, idx_d;
  logic [UW-1:0]     used_q, used_d;
  res_t              res_q, res_d;

  // Memory ports.
  logic              key_we, key_re;
  logic [SW-1:0]     key_waddr;
  logic [15:0]       key_rd;
  logic              slot_we, slot_re;
  logic [SW-1:0]     slot_waddr;
  logic [SLW-1:0]    slot_wdata, slot_rd;
  logic              wt_we, wt_re;
  logic [WAW-1:0]    wt_waddr, wt_raddr;
  logic [7:0]        wt_rd;

  // Fields of the slot entry read back.
  logic signed [CountW-1:0] cnt, cnt_dec, cnt_inc;
  logic [QW-1:0]     head, tail, head_nxt, tail_nxt;
  logic              hit, last, q_full;

  assign cnt  = slot_rd[SLW-1 -: CountW];
  assign head = slot_rd[2*QW-1 -: QW];
  assign tail = slot_rd[QW-1:0];
  assign cnt_dec = cnt - 8'sd1;
  assign cnt_inc = cnt + 8'sd1;
  assign head_nxt = (head == QW'(MAX_WAITERS - 1)) ? '0 : head + QW'(1);
  assign tail_nxt = (tail == QW'(MAX_WAITERS - 1)) ? '0 : tail + QW'(1);
  assign q_full = (cnt <= CountLim) || (cnt == COUNT_MIN);

  assign hit  = (used_q != '0) && (key_rd == key_q);
  assign last = (UW'(idx_q) + UW'(1)) >= used_q;

  assign wt_waddr = WAW'(idx_q) * WAW'(MAX_WAITERS) + WAW'(tail);
  assign wt_raddr = WAW'(idx_q) * WAW'(MAX_WAITERS) + WAW'(head);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  // Next state, memory requests and result formation.
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    key_d      = key_q;
    pid_d      = pid_q;
    idx_d      = idx_q;
    used_d     = used_q;
    res_d      = res_q;
    key_we     = 1'b0;
    key_re     = 1'b0;
    key_waddr  = SW'(used_q);
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_waddr = idx_q;
    slot_wdata = {cnt, head, tail};
    wt_we      = 1'b0;
    wt_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_e'(req_type_i);
          key_d = sem_key_i;
          pid_d = process_id_i;
          idx_d = '0;
          res_d = '0;
          if (req_e'(req_type_i) == REQ_NONE) begin
            state_d = S_RESULT;
          end else begin
            key_re  = 1'b1;
            state_d = S_SCAN;
          end
        end
      end

      // One stored key is compared per cycle.
      S_SCAN: begin
        if (hit) begin
          slot_re = 1'b1;
          state_d = S_EXEC;
        end else if (last) begin
          state_d = S_RESULT;
          if (req_q == REQ_REGISTER) begin
            if (used_q == UW'(NUM_SEMS)) begin
              res_d.status = ST_FULL;
            end else begin
              key_we      = 1'b1;
              slot_we     = 1'b1;
              slot_waddr  = SW'(used_q);
              slot_wdata  = {{1'b0, init_count_i}, {QW{1'b0}}, {QW{1'b0}}};
              used_d      = used_q + UW'(1);
              res_d.status      = ST_OK;
              res_d.count_after = {1'b0, init_count_i};
            end
          end else begin
            res_d.status = ST_UNKNOWN;
          end
        end else begin
          idx_d  = idx_q + SW'(1);
          key_re = 1'b1;
        end
      end

      // Slot entry of the matched key is available.
      S_EXEC: begin
        state_d = S_RESULT;
        res_d.count_after = cnt;
        case (req_q)
          REQ_REGISTER: begin
            res_d.status = ST_EXISTS;
          end
          REQ_WAIT: begin
            if (q_full) begin
              res_d.status = ST_QFULL;
            end else begin
              slot_we = 1'b1;
              res_d.count_after = cnt_dec;
              if (cnt_dec[CountW-1]) begin
                wt_we = 1'b1;
                slot_wdata = {cnt_dec, head, tail_nxt};
                res_d.blocked = 1'b1;
              end else begin
                slot_wdata = {cnt_dec, head, tail};
              end
            end
          end
          REQ_SIGNAL: begin
            if (cnt == COUNT_MAX) begin
              res_d.status = ST_SAT;
            end else begin
              slot_we = 1'b1;
              res_d.count_after = cnt_inc;
              if (cnt_inc[CountW-1] || (cnt_inc == 8'sd0)) begin
                wt_re = 1'b1;
                slot_wdata = {cnt_inc, head_nxt, tail};
                state_d = S_WAKE;
              end else begin
                slot_wdata = {cnt_inc, head, tail};
              end
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end

      // Oldest waiter has been read from its queue.
      S_WAKE: begin
        res_d.wake_valid   = 1'b1;
        res_d.wake_process = wt_rd;
        state_d = S_RESULT;
      end

      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    key_q <= key_d;
    pid_q <= pid_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  // Key store, one key per registered slot.
  cst_ram #(.Width(16), .Depth(NUM_SEMS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .re_i    (key_re),
    .raddr_i (idx_d),
    .rdata_o (key_rd)
  );

  // Slot store: count, queue head and queue tail.
  cst_ram #(.Width(SLW), .Depth(NUM_SEMS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (idx_q),
    .rdata_o (slot_rd)
  );

  // Waiter store, one ring of MAX_WAITERS entries per slot.
  cst_ram #(.Width(8), .Depth(WD)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (pid_q),
    .re_i    (wt_re),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rd)
  );

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(NUM_SEMS))
    else $error("slot fill count beyond table size");

  // A new key is only stored while a free slot remains.
  a_key_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> (used_q < UW'(NUM_SEMS)) && (state_q == S_SCAN))
    else $error("key written into a full table");

  // Only a blocking wait enqueues a waiter.
  a_enqueue_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wt_we |-> (state_q == S_EXEC) && (req_q == REQ_WAIT) && slot_we)
    else $error("waiter written outside a blocking wait");

  // A taken result returns the sequencer to idle.
  a_result_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && res_ready_i) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle");

  // A result never both blocks and wakes.
  a_block_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_q.blocked && res_q.wake_valid))
    else $error("result both blocked and waking");

endmodule

/* sim/counting_semaphore_table_check.sv */
// Checker for the counting semaphore table: predicts each result and compares it.
module counting_semaphore_table_check #(
  parameter int NUM_SEMS    = 16,
  parameter int MAX_WAITERS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [cst_pkg::InitW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [1:0]                req_type_i,
  input  logic [15:0]               sem_key_i,
  input  logic [7:0]                process_id_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [2:0]                status_i,
  input  logic                      blocked_i,
  input  logic                      wake_valid_i,
  input  logic [7:0]                wake_process_i,
  input  logic signed [7:0]         count_after_i,
  output int                        pending_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  // Mirror of the semaphore table.
  logic [InitW-1:0] init_count;
  logic [15:0]      key_tab [NUM_SEMS];
  int               cnt_tab [NUM_SEMS];
  logic [7:0]       waiters [NUM_SEMS][MAX_WAITERS];
  int               q_head  [NUM_SEMS];
  int               q_tail  [NUM_SEMS];
  int               slots_filled;

  // Outcomes of accepted requests, oldest first.
  res_t outcome_q [$];
  res_t want;
  int   mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic flag_mismatch(string what, int got, int expd);
    if (mismatches < 100) begin
      $display("%0t: semaphore result %s got %0d expected %0d", $time, what, got, expd);
    end
    mismatches++;
  endtask

  // Applies one request to the mirrored table and returns the outcome.
  function automatic res_t sem_apply(req_e req, logic [15:0] key, logic [7:0] id);
    res_t r;
    int   s;
    int   c;
    int   i;
    r = '0;
    r.status = ST_OK;
    if (req == REQ_NONE) begin
      return r;
    end
    s = -1;
    for (i = 0; i < slots_filled; i++) begin
      if (s < 0 && key_tab[i] == key) begin
        s = i;
      end
    end
    case (req)
      REQ_REGISTER: begin
        if (s >= 0) begin
          r.status = ST_EXISTS;
          r.count_after = cnt_tab[s][7:0];
        end else if (slots_filled >= NUM_SEMS) begin
          r.status = ST_FULL;
        end else begin
          key_tab[slots_filled] = key;
          cnt_tab[slots_filled] = int'(init_count);
          q_head[slots_filled] = 0;
          q_tail[slots_filled] = 0;
          r.count_after = {1'b0, init_count};
          slots_filled++;
        end
      end
      REQ_WAIT: begin
        if (s < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          c = cnt_tab[s];
          if (c <= -MAX_WAITERS || c <= int'(COUNT_MIN)) begin
            r.status = ST_QFULL;
            r.count_after = c[7:0];
          end else begin
            c--;
            cnt_tab[s] = c;
            // A negative count means the caller sleeps in the queue.
            if (c < 0) begin
              waiters[s][q_tail[s]] = id;
              q_tail[s] = (q_tail[s] + 1) % MAX_WAITERS;
              r.blocked = 1'b1;
            end
            r.count_after = c[7:0];
          end
        end
      end
      default: begin
        if (s < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          c = cnt_tab[s];
          if (c >= int'(COUNT_MAX)) begin
            r.status = ST_SAT;
            r.count_after = c[7:0];
          end else begin
            c++;
            cnt_tab[s] = c;
            // A count still at or below zero releases the oldest sleeper.
            if (c <= 0) begin
              r.wake_valid = 1'b1;
              r.wake_process = waiters[s][q_head[s]];
              q_head[s] = (q_head[s] + 1) % MAX_WAITERS;
            end
            r.count_after = c[7:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  // Watch the three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_count = 7'd1;
      slots_filled = 0;
      outcome_q.delete();
      for (int i = 0; i < NUM_SEMS; i++) begin
        q_head[i] = 0;
        q_tail[i] = 0;
      end
      pending_o <= 0;
    end else begin
      // Results first: an outgoing result always belongs to an earlier request.
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch("with no request pending, status", status_i, 0);
        end else begin
          want = outcome_q.pop_front();
          if (status_i !== want.status) begin
            flag_mismatch("status", status_i, want.status);
          end
          if (blocked_i !== want.blocked) begin
            flag_mismatch("blocked", blocked_i, want.blocked);
          end
          if (wake_valid_i !== want.wake_valid) begin
            flag_mismatch("wake_valid", wake_valid_i, want.wake_valid);
          end
          if (wake_process_i !== want.wake_process) begin
            flag_mismatch("wake_process", wake_process_i, want.wake_process);
          end
          if (count_after_i !== want.count_after) begin
            flag_mismatch("count_after", count_after_i, want.count_after);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        init_count = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        outcome_q.push_back(sem_apply(req_e'(req_type_i), sem_key_i, process_id_i));
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

/* sim/tb_counting_semaphore_table.sv */
// Testbench top for the counting semaphore table: stimulus, flow control and verdict.
module tb_counting_semaphore_table;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  localparam int NumSems    = 16;
  localparam int MaxWaiters = 16;
  localparam int PoolSize   = 20;
  localparam int Phases     = 10;
  localparam int PhaseReqs  = 105;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic [InitW-1:0] cfg_data    = '0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [1:0]       req_type    = REQ_NONE;
  logic [15:0]      sem_key     = '0;
  logic [7:0]       process_id  = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [2:0]       status;
  logic             blocked;
  logic             wake_valid;
  logic [7:0]       wake_process;
  logic signed [7:0] count_after;
  int               pending;
  int               fail_count;

  // Sender and receiver pacing.
  logic hold_on    = 1'b0;
  int   burst_left = 1;
  int   sent_reqs  = 0;
  int   stall_run  = 0;
  int   stall_pct  = 0;

  // Keys used by the stimulus and the ones known to be in the table.
  logic [15:0] key_pool [PoolSize];
  logic [15:0] live_keys [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  counting_semaphore_table #(
    .NUM_SEMS   (NumSems),
    .MAX_WAITERS(MaxWaiters)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .sem_key_i     (sem_key),
    .process_id_i  (process_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .blocked_o     (blocked),
    .wake_valid_o  (wake_valid),
    .wake_process_o(wake_process),
    .count_after_o (count_after)
  );

  counting_semaphore_table_check #(
    .NUM_SEMS   (NumSems),
    .MAX_WAITERS(MaxWaiters)
  ) sem_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .req_type_i    (req_type),
    .sem_key_i     (sem_key),
    .process_id_i  (process_id),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .blocked_i     (blocked),
    .wake_valid_i  (wake_valid),
    .wake_process_i(wake_process),
    .count_after_i (count_after),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Receiver stalls in runs of random length, each run with its own stall rate.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 95;
      endcase
    end
    stall_run--;
    out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // One long receiver hold-off so the block backs up into its input.
  initial begin
    wait (sent_reqs >= 400);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (300) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Offers one request and waits for it to be taken; then maybe a gap.
  task automatic send_req(req_e req, logic [15:0] key, logic [7:0] id);
    int gap;
    bit known;
    in_valid   <= 1'b1;
    req_type   <= req;
    sem_key    <= key;
    process_id <= id;
    do @(posedge clk); while (in_stall);
    sent_reqs++;
    // Track which keys the table should now hold.
    known = 1'b0;
    foreach (live_keys[i]) begin
      if (live_keys[i] == key) begin
        known = 1'b1;
      end
    end
    if (req == REQ_REGISTER && !known && live_keys.size() < NumSems) begin
      live_keys.push_back(key);
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every request has its result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_init(logic [InitW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Main stimulus.
  initial begin
    logic [InitW-1:0] phase_init [Phases];
    logic [15:0]      key;
    bit               dup;
    int               done;
    int               pick;
    int               n;
    int               m;

    phase_init = '{7'd1, 7'd126, 7'd0, 7'($urandom), 7'd127,
                   7'd2, 7'($urandom), 7'd64, 7'($urandom), 7'd1};
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < PoolSize; i++) begin
      do begin
        key_pool[i] = 16'($urandom);
        dup = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (key_pool[j] == key_pool[i]) begin
            dup = 1'b1;
          end
        end
      end while (dup);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored type, unknown keys on wait and signal.
    send_req(REQ_NONE, 16'hFFFF, 8'hFF);
    send_req(REQ_WAIT, 16'h0000, 8'h00);
    send_req(REQ_SIGNAL, 16'hFFFF, 8'hFF);
    drain();

    // Directed: zero start count, duplicate register, fill the wait queue past full.
    write_init(7'd0);
    send_req(REQ_REGISTER, 16'h0000, 8'hFF);
    send_req(REQ_REGISTER, 16'h0000, 8'h00);
    for (int i = 0; i <= MaxWaiters; i++) begin
      send_req(REQ_WAIT, 16'h0000, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
    end
    send_req(REQ_SIGNAL, 16'h0000, 8'hFF);
    drain();

    // Directed: top start count, then a signal that would overflow.
    write_init(7'd127);
    send_req(REQ_REGISTER, 16'hFFFF, 8'h00);
    send_req(REQ_SIGNAL, 16'hFFFF, 8'h00);

    // Random phases, each with its own start count.
    for (int p = 0; p < Phases; p++) begin
      drain();
      write_init(phase_init[p]);
      done = 0;
      while (done < PhaseReqs) begin
        pick = $urandom_range(0, 99);
        if (pick < 55 && live_keys.size() > 0) begin
          // A run of waits on one semaphore, then a run of signals.
          key = live_keys[$urandom_range(0, live_keys.size() - 1)];
          n = $urandom_range(1, 20);
          m = $urandom_range(n / 2, n + 4);
          repeat (n) send_req(REQ_WAIT, key, 8'($urandom));
          repeat (m) send_req(REQ_SIGNAL, key, 8'($urandom));
          done += n + m;
        end else if (pick < 61) begin
          send_req(REQ_REGISTER, key_pool[$urandom_range(0, PoolSize - 1)], 8'($urandom));
          done++;
        end else if (pick < 85 && live_keys.size() > 0) begin
          key = live_keys[$urandom_range(0, live_keys.size() - 1)];
          send_req($urandom_range(0, 1) ? REQ_WAIT : REQ_SIGNAL, key, 8'($urandom));
          done++;
        end else if (pick < 90) begin
          send_req($urandom_range(0, 1) ? REQ_WAIT : REQ_SIGNAL, 16'($urandom), 8'($urandom));
          done++;
        end else if (pick < 95) begin
          key = key_pool[$urandom_range(0, PoolSize - 1)];
          send_req(req_e'($urandom_range(0, 2)), key, 8'($urandom));
          done++;
        end else begin
          send_req(REQ_NONE, 16'($urandom), 8'($urandom));
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("counting_semaphore_table: match");
    end else begin
      $display("counting_semaphore_table: mismatch");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #5_000_000;
    $display("counting_semaphore_table: mismatch");
    $finish;
  end

endmodule
